// ----- sv/crpc_pkg.sv -----
// Shared types, register indexes and constants for the color range pixel counter.
package crpc_pkg;

   localparam int PIX_W        = 8;
   localparam int BOX_W        = 24;
   localparam int CNT_W        = 19;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 24;
   localparam int FRAME_PIXELS = 307200;
   localparam int CNT_MAX      = (2 ** CNT_W) - 1;
   localparam logic [CNT_W-1:0] CNT_SAT =
      CNT_W'((FRAME_PIXELS < CNT_MAX) ? FRAME_PIXELS : CNT_MAX);

   localparam logic [CSR_IDX_W-1:0] REG_BLUE_LOWER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_UPPER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_LOWER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_UPPER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RED_LOWER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RED_UPPER   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_TH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_CLEAR_TH    = 3'd7;

   localparam logic [BOX_W-1:0] RST_BLUE_LOWER  = 24'd50;
   localparam logic [BOX_W-1:0] RST_BLUE_UPPER  = 24'd1643630;
   localparam logic [BOX_W-1:0] RST_GREEN_LOWER = 24'd7680;
   localparam logic [BOX_W-1:0] RST_GREEN_UPPER = 24'd1658925;
   localparam logic [BOX_W-1:0] RST_RED_LOWER   = 24'd6553600;
   localparam logic [BOX_W-1:0] RST_RED_UPPER   = 24'd10488345;
   localparam logic [CNT_W-1:0] RST_DETECT_TH   = 19'd3000;
   localparam logic [CNT_W-1:0] RST_CLEAR_TH    = 19'd200;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_blue;
      logic [PIX_W-1:0] pixel_green;
      logic [PIX_W-1:0] pixel_red;
      logic             frame_last;
   } req_type;

   typedef struct packed {
      logic             hit_blue;
      logic             hit_green;
      logic             hit_red;
      logic             hit_any;
      logic             frame_done;
      logic [CNT_W-1:0] count_blue;
      logic [CNT_W-1:0] count_green;
      logic [CNT_W-1:0] count_red;
      logic [CNT_W-1:0] count_any;
      logic             detected_blue;
      logic             detected_green;
      logic             detected_red;
   } rsp_type;

   typedef struct packed {
      logic [BOX_W-1:0] blue_lower;
      logic [BOX_W-1:0] blue_upper;
      logic [BOX_W-1:0] green_lower;
      logic [BOX_W-1:0] green_upper;
      logic [BOX_W-1:0] red_lower;
      logic [BOX_W-1:0] red_upper;
      logic [CNT_W-1:0] detect_threshold;
      logic [CNT_W-1:0] clear_threshold;
   } cfg_type;

   typedef struct packed {
      logic blue;
      logic green;
      logic red;
      logic any;
   } hits_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_blue;
      logic [CNT_W-1:0] count_green;
      logic [CNT_W-1:0] count_red;
      logic [CNT_W-1:0] count_any;
      logic             detected_blue;
      logic             detected_green;
      logic             detected_red;
   } stats_type;

endpackage

// ----- sv/crpc_csr.sv -----
// Configuration registers of the color range pixel counter.
module crpc_csr import crpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BLUE_LOWER:  cfg_in.blue_lower       = csr_wdata[BOX_W-1:0];
            REG_BLUE_UPPER:  cfg_in.blue_upper       = csr_wdata[BOX_W-1:0];
            REG_GREEN_LOWER: cfg_in.green_lower      = csr_wdata[BOX_W-1:0];
            REG_GREEN_UPPER: cfg_in.green_upper      = csr_wdata[BOX_W-1:0];
            REG_RED_LOWER:   cfg_in.red_lower        = csr_wdata[BOX_W-1:0];
            REG_RED_UPPER:   cfg_in.red_upper        = csr_wdata[BOX_W-1:0];
            REG_DETECT_TH:   cfg_in.detect_threshold = csr_wdata[CNT_W-1:0];
            REG_CLEAR_TH:    cfg_in.clear_threshold  = csr_wdata[CNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blue_lower       <= RST_BLUE_LOWER;
         cfg_ff.blue_upper       <= RST_BLUE_UPPER;
         cfg_ff.green_lower      <= RST_GREEN_LOWER;
         cfg_ff.green_upper      <= RST_GREEN_UPPER;
         cfg_ff.red_lower        <= RST_RED_LOWER;
         cfg_ff.red_upper        <= RST_RED_UPPER;
         cfg_ff.detect_threshold <= RST_DETECT_TH;
         cfg_ff.clear_threshold  <= RST_CLEAR_TH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/crpc_classify.sv -----
// Per-channel box compare of one pixel against the three color boxes.
module crpc_classify import crpc_pkg::*; (
   input  req_type  pix,
   input  cfg_type  cfg,
   output hits_type hits
);

   function automatic logic in_box(input req_type p, input logic [BOX_W-1:0] lo,
                                   input logic [BOX_W-1:0] hi);
      logic b_ok;
      logic g_ok;
      logic r_ok;
      b_ok = (p.pixel_blue  >= lo[7:0])   && (p.pixel_blue  <= hi[7:0]);
      g_ok = (p.pixel_green >= lo[15:8])  && (p.pixel_green <= hi[15:8]);
      r_ok = (p.pixel_red   >= lo[23:16]) && (p.pixel_red   <= hi[23:16]);
      return b_ok && g_ok && r_ok;
   endfunction

   always_comb begin
      hits.blue  = in_box(pix, cfg.blue_lower,  cfg.blue_upper);
      hits.green = in_box(pix, cfg.green_lower, cfg.green_upper);
      hits.red   = in_box(pix, cfg.red_lower,   cfg.red_upper);
      hits.any   = hits.blue || hits.green || hits.red;
   end

endmodule

// ----- sv/crpc_accum.sv -----
// Per-frame saturating match counters and latched detection flags.
module crpc_accum import crpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             last,
   input  hits_type         hits,
   input  logic [CNT_W-1:0] detect_threshold,
   input  logic [CNT_W-1:0] clear_threshold,
   output stats_type        stats
);

   logic [CNT_W-1:0] run_blue_ff,  run_blue_in,  inc_blue;
   logic [CNT_W-1:0] run_green_ff, run_green_in, inc_green;
   logic [CNT_W-1:0] run_red_ff,   run_red_in,   inc_red;
   logic [CNT_W-1:0] run_any_ff,   run_any_in,   inc_any;
   logic [2:0]       flags_ff, flags_in, flags_end;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic hit);
      return (hit && (c < CNT_SAT)) ? c + CNT_W'(1) : c;
   endfunction

   always_comb begin
      inc_blue  = sat_inc(run_blue_ff,  hits.blue);
      inc_green = sat_inc(run_green_ff, hits.green);
      inc_red   = sat_inc(run_red_ff,   hits.red);
      inc_any   = sat_inc(run_any_ff,   hits.any);

      flags_end = flags_ff | {inc_red >= detect_threshold,
                              inc_green >= detect_threshold,
                              inc_blue >= detect_threshold};
      if (inc_any < clear_threshold) begin
         flags_end = 3'b000;
      end

      run_blue_in  = run_blue_ff;
      run_green_in = run_green_ff;
      run_red_in   = run_red_ff;
      run_any_in   = run_any_ff;
      flags_in     = flags_ff;
      if (advance) begin
         if (last) begin
            run_blue_in  = '0;
            run_green_in = '0;
            run_red_in   = '0;
            run_any_in   = '0;
            flags_in     = flags_end;
         end else begin
            run_blue_in  = inc_blue;
            run_green_in = inc_green;
            run_red_in   = inc_red;
            run_any_in   = inc_any;
         end
      end

      stats.count_blue     = last ? inc_blue  : '0;
      stats.count_green    = last ? inc_green : '0;
      stats.count_red      = last ? inc_red   : '0;
      stats.count_any      = last ? inc_any   : '0;
      stats.detected_blue  = last ? flags_end[0] : flags_ff[0];
      stats.detected_green = last ? flags_end[1] : flags_ff[1];
      stats.detected_red   = last ? flags_end[2] : flags_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_blue_ff  <= '0;
         run_green_ff <= '0;
         run_red_ff   <= '0;
         run_any_ff   <= '0;
         flags_ff     <= '0;
      end else begin
         run_blue_ff  <= run_blue_in;
         run_green_ff <= run_green_in;
         run_red_ff   <= run_red_in;
         run_any_ff   <= run_any_in;
         flags_ff     <= flags_in;
      end
   end

endmodule

// ----- sv/color_range_pixel_counter.sv -----
// Color range pixel counter: pixel classification with per-frame counts and detection flags.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) takes one BGR pixel per item, with
//   frame_last marking the final pixel of a frame. rsp channel (rsp_valid/rsp_ready/
//   rsp_payload) returns one item per pixel: the three box hits, the combined mask bit,
//   and on the last pixel the frame counts and updated detection flags.
//   csr port writes a register on any cycle with csr_we high; write only while idle.
// Timing:
//   One item per cycle sustained while rsp_ready stays high. An item enters an input
//   register on acceptance, and its result moves into the output register, which drives
//   rsp_valid, once that is free. The box compares and the counter update sit between them.
// Reset:
//   Synchronous; registers return to their default values, counters and flags clear,
//   both pipeline stages empty.
// Backpressure:
//   While rsp_ready is low the result holds; the input register still takes one more
//   item, then req_ready drops until the output drains.
module color_range_pixel_counter import crpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg;
   hits_type  hits;
   stats_type stats;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    out_free;
   logic    s1_move;
   logic    req_take;

   crpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   crpc_classify u_classify (
      .pix  (s1_data_ff),
      .cfg  (cfg),
      .hits (hits)
   );

   crpc_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .advance          (s1_move),
      .last             (s1_data_ff.frame_last),
      .hits             (hits),
      .detect_threshold (cfg.detect_threshold),
      .clear_threshold  (cfg.clear_threshold),
      .stats            (stats)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
      end

      out_data_in.hit_blue       = hits.blue;
      out_data_in.hit_green      = hits.green;
      out_data_in.hit_red        = hits.red;
      out_data_in.hit_any        = hits.any;
      out_data_in.frame_done     = s1_data_ff.frame_last;
      out_data_in.count_blue     = stats.count_blue;
      out_data_in.count_green    = stats.count_green;
      out_data_in.count_red      = stats.count_red;
      out_data_in.count_any      = stats.count_any;
      out_data_in.detected_blue  = stats.detected_blue;
      out_data_in.detected_green = stats.detected_green;
      out_data_in.detected_red   = stats.detected_red;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_payload;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

`ifndef NO_ASSERTIONS
   a_mid_frame_counts_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.frame_done) |->
         (rsp_payload.count_blue == '0 && rsp_payload.count_green == '0 &&
          rsp_payload.count_red == '0 && rsp_payload.count_any == '0))
      else $error("nonzero count on a pixel that is not the last of its frame");

   a_any_bounds_colors: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.frame_done) |->
         (rsp_payload.count_blue <= rsp_payload.count_any &&
          rsp_payload.count_green <= rsp_payload.count_any &&
          rsp_payload.count_red <= rsp_payload.count_any))
      else $error("combined count below a per-color count");

   a_clear_wins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.frame_done &&
       rsp_payload.count_any < cfg.clear_threshold) |->
         (!rsp_payload.detected_blue && !rsp_payload.detected_green &&
          !rsp_payload.detected_red))
      else $error("detection flag left set below the clear threshold");

   a_input_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("input register overwritten before its item moved on");
`endif

endmodule

// ----- bench/pixel_count_checker.sv -----
// Checker for the color range pixel counter: tracks registers, predicts and compares results.
`timescale 1ns / 100ps
module pixel_count_checker import crpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    outstanding,
   output int                    mismatches
);

   cfg_type          regs;
   logic [CNT_W-1:0] run_blue, run_green, run_red, run_any;
   logic             latched_blue, latched_green, latched_red;
   rsp_type          pending_pixels[$];
   int               result_index = 0;
   int               mismatch_count = 0;

   assign mismatches = mismatch_count;

   task automatic report(input string msg);
      if (mismatch_count < 100)
         $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                              input logic [CNT_W-1:0] want);
      if (got !== want)
         report($sformatf("result %0d %s is %0d, expected %0d", result_index, name, got, want));
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      check_field("hit_blue", CNT_W'(got.hit_blue), CNT_W'(want.hit_blue));
      check_field("hit_green", CNT_W'(got.hit_green), CNT_W'(want.hit_green));
      check_field("hit_red", CNT_W'(got.hit_red), CNT_W'(want.hit_red));
      check_field("hit_any", CNT_W'(got.hit_any), CNT_W'(want.hit_any));
      check_field("frame_done", CNT_W'(got.frame_done), CNT_W'(want.frame_done));
      check_field("count_blue", got.count_blue, want.count_blue);
      check_field("count_green", got.count_green, want.count_green);
      check_field("count_red", got.count_red, want.count_red);
      check_field("count_any", got.count_any, want.count_any);
      check_field("detected_blue", CNT_W'(got.detected_blue), CNT_W'(want.detected_blue));
      check_field("detected_green", CNT_W'(got.detected_green), CNT_W'(want.detected_green));
      check_field("detected_red", CNT_W'(got.detected_red), CNT_W'(want.detected_red));
   endtask

   function automatic logic in_box(input req_type p, input logic [BOX_W-1:0] lo,
                                   input logic [BOX_W-1:0] hi);
      return p.pixel_blue >= lo[7:0] && p.pixel_blue <= hi[7:0] &&
             p.pixel_green >= lo[15:8] && p.pixel_green <= hi[15:8] &&
             p.pixel_red >= lo[23:16] && p.pixel_red <= hi[23:16];
   endfunction

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c, input logic hit);
      return (hit && c < CNT_SAT) ? c + CNT_W'(1) : c;
   endfunction

   function automatic rsp_type count_pixel(input req_type p);
      rsp_type r;
      logic    hb, hg, hr;
      hb = in_box(p, regs.blue_lower, regs.blue_upper);
      hg = in_box(p, regs.green_lower, regs.green_upper);
      hr = in_box(p, regs.red_lower, regs.red_upper);
      run_blue  = bump(run_blue, hb);
      run_green = bump(run_green, hg);
      run_red   = bump(run_red, hr);
      run_any   = bump(run_any, hb || hg || hr);
      r = '0;
      r.hit_blue   = hb;
      r.hit_green  = hg;
      r.hit_red    = hr;
      r.hit_any    = hb || hg || hr;
      r.frame_done = p.frame_last;
      if (p.frame_last) begin
         r.count_blue  = run_blue;
         r.count_green = run_green;
         r.count_red   = run_red;
         r.count_any   = run_any;
         if (run_blue >= regs.detect_threshold) latched_blue = 1'b1;
         if (run_green >= regs.detect_threshold) latched_green = 1'b1;
         if (run_red >= regs.detect_threshold) latched_red = 1'b1;
         if (run_any < regs.clear_threshold) begin
            latched_blue  = 1'b0;
            latched_green = 1'b0;
            latched_red   = 1'b0;
         end
         run_blue  = '0;
         run_green = '0;
         run_red   = '0;
         run_any   = '0;
      end
      r.detected_blue  = latched_blue;
      r.detected_green = latched_green;
      r.detected_red   = latched_red;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         regs = cfg_type'{blue_lower: RST_BLUE_LOWER, blue_upper: RST_BLUE_UPPER,
                          green_lower: RST_GREEN_LOWER, green_upper: RST_GREEN_UPPER,
                          red_lower: RST_RED_LOWER, red_upper: RST_RED_UPPER,
                          detect_threshold: RST_DETECT_TH, clear_threshold: RST_CLEAR_TH};
         run_blue      = '0;
         run_green     = '0;
         run_red       = '0;
         run_any       = '0;
         latched_blue  = 1'b0;
         latched_green = 1'b0;
         latched_red   = 1'b0;
         pending_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0)
               report($sformatf("result %0d arrived with no pixel pending", result_index));
            else
               check_result(rsp_payload, pending_pixels.pop_front());
            result_index++;
         end
         if (csr_we) begin
            case (csr_index)
               REG_BLUE_LOWER:  regs.blue_lower = csr_wdata;
               REG_BLUE_UPPER:  regs.blue_upper = csr_wdata;
               REG_GREEN_LOWER: regs.green_lower = csr_wdata;
               REG_GREEN_UPPER: regs.green_upper = csr_wdata;
               REG_RED_LOWER:   regs.red_lower = csr_wdata;
               REG_RED_UPPER:   regs.red_upper = csr_wdata;
               REG_DETECT_TH:   regs.detect_threshold = csr_wdata[CNT_W-1:0];
               REG_CLEAR_TH:    regs.clear_threshold = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_pixels.push_back(count_pixel(req_payload));
      end
      outstanding <= pending_pixels.size();
   end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the color range pixel counter: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import crpc_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 150;

   typedef enum int {PICK_INSIDE, PICK_LOW, PICK_HIGH, PICK_BELOW, PICK_ABOVE, PICK_ANY}
      pick_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_BLUE_LOWER;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    outstanding;
   int                    mismatches;

   cfg_type cur = cfg_type'{blue_lower: RST_BLUE_LOWER, blue_upper: RST_BLUE_UPPER,
                            green_lower: RST_GREEN_LOWER, green_upper: RST_GREEN_UPPER,
                            red_lower: RST_RED_LOWER, red_upper: RST_RED_UPPER,
                            detect_threshold: RST_DETECT_TH, clear_threshold: RST_CLEAR_TH};
   int gap_pct = 0;
   bit quiet = 1'b0;
   int pixels_sent = 0;
   int frames_sent = 0;
   int settings_used = 1;
   int idle_cycles = 0;
   int ready_hold = 0;

   color_range_pixel_counter uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   pixel_count_checker counts_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (quiet || reset || !rsp_ready) begin
         rsp_ready  <= 1'b1;
         ready_hold <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(0, 12);
      end else begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("color_range_pixel_counter regression: fail");
         $finish;
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] r, input logic last);
      req_type p;
      p.pixel_blue  = b;
      p.pixel_green = g;
      p.pixel_red   = r;
      p.frame_last  = last;
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
      if (last) frames_sent++;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= REG_BLUE_LOWER;
      csr_wdata <= c.blue_lower;
      @(posedge clock);
      csr_index <= REG_BLUE_UPPER;
      csr_wdata <= c.blue_upper;
      @(posedge clock);
      csr_index <= REG_GREEN_LOWER;
      csr_wdata <= c.green_lower;
      @(posedge clock);
      csr_index <= REG_GREEN_UPPER;
      csr_wdata <= c.green_upper;
      @(posedge clock);
      csr_index <= REG_RED_LOWER;
      csr_wdata <= c.red_lower;
      @(posedge clock);
      csr_index <= REG_RED_UPPER;
      csr_wdata <= c.red_upper;
      @(posedge clock);
      csr_index <= REG_DETECT_TH;
      csr_wdata <= {(CSR_DATA_W-CNT_W)'($urandom), c.detect_threshold};
      @(posedge clock);
      csr_index <= REG_CLEAR_TH;
      csr_wdata <= {(CSR_DATA_W-CNT_W)'($urandom), c.clear_threshold};
      @(posedge clock);
      csr_we <= 1'b0;
      cur = c;
      settings_used++;
   endtask

   function automatic void random_box(output logic [BOX_W-1:0] lo,
                                      output logic [BOX_W-1:0] hi);
      int shape;
      int ch;
      int l;
      shape = $urandom_range(0, 9);
      lo = '0;
      hi = '1;
      if (shape == 1) begin
         ch = $urandom_range(0, 2);
         l  = $urandom_range(1, 255);
         lo[ch*8 +: 8] = 8'(l);
         hi[ch*8 +: 8] = 8'($urandom_range(0, l - 1));
      end else if (shape >= 2) begin
         for (int c = 0; c < 3; c++) begin
            l = $urandom_range(0, 255);
            lo[c*8 +: 8] = 8'(l);
            hi[c*8 +: 8] = (shape < 5) ? 8'($urandom_range(l, (l > 247) ? 255 : l + 8))
                                       : 8'($urandom_range(l, 255));
         end
      end
   endfunction

   function automatic logic [CNT_W-1:0] random_threshold(input int span);
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return CNT_SAT;
         default: return CNT_W'($urandom_range(0, span));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_byte(input logic [PIX_W-1:0] lo,
                                                  input logic [PIX_W-1:0] hi,
                                                  input pick_kind_type kind);
      case (kind)
         PICK_INSIDE: return (lo <= hi) ? 8'($urandom_range(int'(lo), int'(hi)))
                                        : 8'($urandom);
         PICK_LOW:    return lo;
         PICK_HIGH:   return hi;
         PICK_BELOW:  return lo - 8'd1;
         PICK_ABOVE:  return hi + 8'd1;
         default:     return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_pixel(input logic last);
      logic [BOX_W-1:0] lo, hi;
      pick_kind_type    kinds [3];
      int               roll;
      int               odd_ch;
      case ($urandom_range(0, 2))
         0: begin
            lo = cur.blue_lower;
            hi = cur.blue_upper;
         end
         1: begin
            lo = cur.green_lower;
            hi = cur.green_upper;
         end
         default: begin
            lo = cur.red_lower;
            hi = cur.red_upper;
         end
      endcase
      roll   = $urandom_range(0, 9);
      odd_ch = $urandom_range(0, 2);
      for (int ch = 0; ch < 3; ch++) begin
         if (roll < 3)
            kinds[ch] = PICK_ANY;
         else if (roll < 8 || ch != odd_ch)
            kinds[ch] = PICK_INSIDE;
         else
            kinds[ch] = pick_kind_type'($urandom_range(PICK_LOW, PICK_ABOVE));
      end
      send_pixel(pick_byte(lo[7:0], hi[7:0], kinds[0]),
                 pick_byte(lo[15:8], hi[15:8], kinds[1]),
                 pick_byte(lo[23:16], hi[23:16], kinds[2]), last);
   endtask

   task automatic send_frame(input int len);
      for (int i = 0; i < len; i++)
         send_random_pixel(i == len - 1);
   endtask

   task automatic run_phase(input int items, input int idle_pct);
      cfg_type c;
      int      sent;
      int      len;
      settle();
      random_box(c.blue_lower, c.blue_upper);
      random_box(c.green_lower, c.green_upper);
      random_box(c.red_lower, c.red_upper);
      c.detect_threshold = random_threshold(12);
      c.clear_threshold  = random_threshold(6);
      write_settings(c);
      gap_pct = idle_pct;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
         send_frame(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;

      send_pixel(8'd80, 8'd10, 8'd10, 1'b0);
      send_pixel(8'd20, 8'd50, 8'd10, 1'b0);
      send_pixel(8'd10, 8'd5, 8'd130, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

      settle();
      write_settings(cfg_type'{blue_lower: '0, blue_upper: '1,
                               green_lower: 24'h807F01, green_upper: 24'h807F01,
                               red_lower: 24'h101010, red_upper: 24'hF0F0F0,
                               detect_threshold: 19'd1, clear_threshold: '0});
      send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h01, 8'h7F, 8'h80, 1'b0);
      send_pixel(8'h10, 8'h10, 8'h10, 1'b0);
      send_pixel(8'hF0, 8'hF0, 8'hF0, 1'b0);
      send_pixel(8'h0F, 8'h10, 8'h10, 1'b0);
      send_pixel(8'hF0, 8'hF0, 8'hF1, 1'b1);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);

      // inverted boxes; detect at zero while clear at maximum
      settle();
      write_settings(cfg_type'{blue_lower: '1, blue_upper: '0,
                               green_lower: 24'h00FF00, green_upper: 24'hFFFEFF,
                               red_lower: '0, red_upper: '1,
                               detect_threshold: '0, clear_threshold: '1});
      send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFE, 8'hFF, 1'b1);

      for (int p = 0; p < PHASES; p++)
         run_phase(PHASE_ITEMS, (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40));

      // hold both sides busy; set flags with counts at the thresholds, then clear them
      settle();
      quiet   = 1'b1;
      gap_pct = 0;
      write_settings(cfg_type'{blue_lower: '0, blue_upper: '1,
                               green_lower: '0, green_upper: '1,
                               red_lower: '0, red_upper: '1,
                               detect_threshold: 19'd60, clear_threshold: 19'd60});
      send_frame(60);
      send_frame(12);
      settle();

      $display("covered %0d pixels in %0d frames under %0d register settings", pixels_sent,
               frames_sent, settings_used);
      $display("incl. inverted, single-point and full boxes, threshold extremes and edges");
      if (mismatches == 0 && outstanding == 0)
         $display("color_range_pixel_counter regression: pass");
      else
         $display("color_range_pixel_counter regression: fail");
      $finish;
   end

endmodule

// ----- files.f -----
sv/crpc_pkg.sv
sv/crpc_csr.sv
sv/crpc_classify.sv
sv/crpc_accum.sv
sv/color_range_pixel_counter.sv
bench/pixel_count_checker.sv
bench/tb.sv
